// ===== rtl/sng_pkg.sv =====
`timescale 1ns / 1ps

package sng_pkg;

  // Defaults for the top level parameters
  localparam int MAX_SURFELS_DEF    = 32;
  localparam int MAX_FRAMES_DEF     = 8;
  localparam int COORD_BITS_DEF     = 12;

  // Fixed field widths
  localparam int FRAME_W            = 8;
  localparam int PIX_W              = 12;
  localparam int IDX_W              = 5;
  localparam int MASK_OUT_W         = 32;

  // Input command codes
  localparam logic CMD_ADD          = 1'b0;
  localparam logic CMD_CLEAR        = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CNT,
    ST_RD,
    ST_CMP,
    ST_EMIT
  } state_t;

  // Result of one compare-unit pass
  typedef struct packed {
    logic feq;
    logic flt;
    logic adj;
  } cmp_t;

endpackage

// ===== rtl/sng_if.sv =====
`timescale 1ns / 1ps

interface sng_in_if import sng_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               cmd;
  logic [FRAME_W-1:0] frame_index;
  logic [PIX_W-1:0]   pixel_x;
  logic [PIX_W-1:0]   pixel_y;
  logic               last_entry;

  modport source (output valid, cmd, frame_index, pixel_x, pixel_y, last_entry,
                  input ready);
  modport sink   (input valid, cmd, frame_index, pixel_x, pixel_y, last_entry,
                  output ready);
endinterface

interface sng_out_if import sng_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [IDX_W-1:0]      surfel_index;
  logic [MASK_OUT_W-1:0] neighbour_mask;
  logic                  overflow;

  modport source (output valid, surfel_index, neighbour_mask, overflow,
                  input ready);
  modport sink   (input valid, surfel_index, neighbour_mask, overflow,
                  output ready);
endinterface

// ===== rtl/sng_ram.sv =====
`timescale 1ns / 1ps

module sng_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr_a,
  output logic [WIDTH-1:0] rd_data_a,
  input  logic [AW-1:0]    rd_addr_b,
  output logic [WIDTH-1:0] rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

// ===== rtl/sng_adj.sv =====
`timescale 1ns / 1ps

// Shared compare unit: frame order plus pixel adjacency of two entries.
module sng_adj import sng_pkg::*; #(
  parameter int CW = COORD_BITS_DEF
) (
  input  logic [FRAME_W-1:0] frame_a,
  input  logic [CW-1:0]      x_a,
  input  logic [CW-1:0]      y_a,
  input  logic [FRAME_W-1:0] frame_b,
  input  logic [CW-1:0]      x_b,
  input  logic [CW-1:0]      y_b,
  input  logic               eight_conn,
  output cmp_t               res
);

  logic [CW-1:0] dx;
  logic [CW-1:0] dy;
  logic          dx0, dy0, dx1, dy1;

  always_comb begin
    dx  = (x_a >= x_b) ? (x_a - x_b) : (x_b - x_a);
    dy  = (y_a >= y_b) ? (y_a - y_b) : (y_b - y_a);
    dx0 = (dx == '0);
    dy0 = (dy == '0);
    dx1 = (dx == CW'(1));
    dy1 = (dy == CW'(1));

    res.feq = (frame_a == frame_b);
    res.flt = (frame_a < frame_b);
    if (eight_conn) begin
      res.adj = (dx0 || dx1) && (dy0 || dy1) && !(dx0 && dy0);
    end else begin
      res.adj = (dx1 && dy0) || (dx0 && dy1);
    end
  end

endmodule

// ===== rtl/surfel_neighbour_graph.sv =====
`timescale 1ns / 1ps

// Channel  Dir  Word                                              Notes
// in_ch    in   cmd, frame_index, pixel_x, pixel_y, last_entry    one entry or a clear
// out_ch   out  surfel_index, neighbour_mask, overflow            one word per finished surfel
// cfg      in   cfg_we, cfg_wdata                                 8- or 4-connected select
//
// A clear or a non-final entry leaves the block idle. A final entry runs the walk:
// per earlier surfel, a fetch of its entry count, then the walk steps
// through the compare unit (at most ns + nt - 1 steps, each step one registered
// read of both entry-RAM ports), then a move to the next surfel; last, a load of
// the output register. A final entry into an empty or full store goes straight
// to the load. in_ch.ready is low for the whole walk.
// Reset is synchronous, active low; no clearing pass, store contents are only
// read once written. A stalled out_ch holds the block in its emit state.
module surfel_neighbour_graph import sng_pkg::*; #(
  parameter int MAX_SURFELS           = MAX_SURFELS_DEF,
  parameter int MAX_FRAMES_PER_SURFEL = MAX_FRAMES_DEF,
  parameter int COORD_BITS            = COORD_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  sng_in_if.sink      in_ch,
  sng_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic        cfg_wdata
);

  localparam int MF     = MAX_FRAMES_PER_SURFEL;
  localparam int CW     = (COORD_BITS < PIX_W) ? COORD_BITS : PIX_W;
  localparam int EW     = FRAME_W + 2 * CW;            // packed entry width
  localparam int DEPTH  = MAX_SURFELS * MF;
  localparam int AW     = $clog2(DEPTH);
  localparam int BW     = $clog2(DEPTH + 1);           // base pointer width
  localparam int SW     = $clog2(MAX_SURFELS + 1);     // surfel count width
  localparam int TW     = $clog2(MAX_SURFELS);         // slot index width
  localparam int FW     = $clog2(MF + 1);              // entry count width
  localparam int MASK_W = (MAX_SURFELS > MASK_OUT_W) ? MAX_SURFELS : MASK_OUT_W;

  state_t state_r, state_nxt;

  // configuration and store bookkeeping
  logic              eight_r;
  logic [SW-1:0]     stored_r;
  logic [BW-1:0]     base_s_r;     // first entry slot of the surfel being received
  logic [FW-1:0]     fill_r;
  logic              dropped_r;
  logic              full_r;       // final entry came in with the store full

  // walk pointers
  logic [TW-1:0]     t_r;          // earlier surfel under test
  logic [BW-1:0]     base_t_r;
  logic [FW-1:0]     i_r;          // walk pointer, new surfel
  logic [FW-1:0]     j_r;          // walk pointer, earlier surfel
  logic [MASK_W-1:0] mask_r;

  // output register
  logic                  out_valid_r;
  logic [IDX_W-1:0]      out_idx_r;
  logic [MASK_OUT_W-1:0] out_mask_r;
  logic                  out_ovf_r;

  logic          in_acc, is_add, is_clr, is_last;
  logic          full, room, step_ok, last_t, out_free, hit;
  logic [FW-1:0] fill_inc;

  logic          ent_we;
  logic [AW-1:0] ent_wr_addr, ent_rd_addr_a, ent_rd_addr_b;
  logic [EW-1:0] ent_wr_data, ent_a, ent_b;
  logic          cnt_we;
  logic [FW-1:0] cnt_rd;
  cmp_t          cmp;

  // ---------------------------------------------------------------------------
  // handshake decode
  assign in_acc   = in_ch.valid && in_ch.ready;
  assign is_add   = in_acc && (in_ch.cmd == CMD_ADD);
  assign is_clr   = in_acc && (in_ch.cmd == CMD_CLEAR);
  assign is_last  = is_add && in_ch.last_entry;
  assign full     = (stored_r == SW'(MAX_SURFELS));
  assign room     = (fill_r < FW'(MF));
  assign fill_inc = room ? (fill_r + FW'(1)) : fill_r;
  assign out_free = !out_valid_r || out_ch.ready;

  // walk condition and end-of-list test
  assign step_ok  = (i_r < fill_r) && (j_r < cnt_rd);
  assign last_t   = ((SW'(t_r) + SW'(1)) == stored_r);
  assign hit      = cmp.feq && cmp.adj;

  // ---------------------------------------------------------------------------
  // entry store: one packed word per entry, two read ports for the walk
  assign ent_wr_data   = {in_ch.frame_index, in_ch.pixel_x[CW-1:0], in_ch.pixel_y[CW-1:0]};
  assign ent_wr_addr   = AW'(base_s_r + BW'(fill_r));
  assign ent_rd_addr_a = AW'(base_s_r + BW'(i_r));
  assign ent_rd_addr_b = AW'(base_t_r + BW'(j_r));

  sng_ram #(
    .WIDTH (EW),
    .DEPTH (DEPTH)
  ) u_ent_ram (
    .clk       (clk),
    .we        (ent_we),
    .wr_addr   (ent_wr_addr),
    .wr_data   (ent_wr_data),
    .rd_addr_a (ent_rd_addr_a),
    .rd_data_a (ent_a),
    .rd_addr_b (ent_rd_addr_b),
    .rd_data_b (ent_b)
  );

  // entry counts per completed surfel; read address follows t_r
  sng_ram #(
    .WIDTH (FW),
    .DEPTH (MAX_SURFELS)
  ) u_cnt_ram (
    .clk       (clk),
    .we        (cnt_we),
    .wr_addr   (TW'(stored_r)),
    .wr_data   (fill_inc),
    .rd_addr_a (t_r),
    .rd_data_a (cnt_rd),
    .rd_addr_b (t_r),
    .rd_data_b ()
  );

  sng_adj #(
    .CW (CW)
  ) u_adj (
    .frame_a    (ent_a[EW-1 -: FRAME_W]),
    .x_a        (ent_a[2*CW-1 -: CW]),
    .y_a        (ent_a[CW-1:0]),
    .frame_b    (ent_b[EW-1 -: FRAME_W]),
    .x_b        (ent_b[2*CW-1 -: CW]),
    .y_b        (ent_b[CW-1:0]),
    .eight_conn (eight_r),
    .res        (cmp)
  );

  // ---------------------------------------------------------------------------
  // sequencer: next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (is_last) begin
          if (full || (stored_r == '0)) begin
            state_nxt = ST_EMIT;
          end else begin
            state_nxt = ST_CNT;
          end
        end
      end
      ST_CNT: begin
        state_nxt = ST_RD;
      end
      ST_RD: begin
        if (step_ok) begin
          state_nxt = ST_CMP;
        end else begin
          state_nxt = last_t ? ST_EMIT : ST_CNT;
        end
      end
      ST_CMP: begin
        if (hit) begin
          state_nxt = last_t ? ST_EMIT : ST_CNT;
        end else begin
          state_nxt = ST_RD;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // sequencer: outputs
  always_comb begin
    in_ch.ready = (state_r == ST_IDLE);
    ent_we      = is_add && !full && room;
    cnt_we      = is_last && !full;
  end

  // ---------------------------------------------------------------------------
  // registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      eight_r     <= 1'b0;
      stored_r    <= '0;
      base_s_r    <= '0;
      fill_r      <= '0;
      dropped_r   <= 1'b0;
      full_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        eight_r <= cfg_wdata;
      end
      // load wins over drain: out_free already covers the word leaving now
      if ((state_r == ST_EMIT) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (is_clr) begin
            stored_r  <= '0;
            base_s_r  <= '0;
            fill_r    <= '0;
            dropped_r <= 1'b0;
          end else if (is_add) begin
            if (full) begin
              dropped_r <= 1'b1;
              fill_r    <= '0;
              full_r    <= 1'b1;
            end else begin
              full_r <= 1'b0;
              fill_r <= fill_inc;
              if (!room) begin
                dropped_r <= 1'b1;
              end
            end
            t_r      <= '0;
            base_t_r <= '0;
            i_r      <= '0;
            j_r      <= '0;
            mask_r   <= '0;
          end
        end
        ST_CNT: begin
        end
        ST_RD: begin
          if (!step_ok) begin
            t_r      <= t_r + TW'(1);
            base_t_r <= base_t_r + BW'(MF);
            i_r      <= '0;
            j_r      <= '0;
          end
        end
        ST_CMP: begin
          priority if (hit) begin
            mask_r   <= mask_r | (MASK_W'(1) << t_r);
            t_r      <= t_r + TW'(1);
            base_t_r <= base_t_r + BW'(MF);
            i_r      <= '0;
            j_r      <= '0;
          end else if (cmp.feq) begin
            i_r <= i_r + FW'(1);
            j_r <= j_r + FW'(1);
          end else if (cmp.flt) begin
            i_r <= i_r + FW'(1);
          end else begin
            j_r <= j_r + FW'(1);
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            out_idx_r   <= full_r ? '0 : IDX_W'(stored_r);
            out_mask_r  <= mask_r[MASK_OUT_W-1:0];
            out_ovf_r   <= dropped_r;
            fill_r      <= '0;
            if (!full_r) begin
              stored_r <= stored_r + SW'(1);
              base_s_r <= base_s_r + BW'(MF);
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.surfel_index   = out_idx_r;
  assign out_ch.neighbour_mask = out_mask_r;
  assign out_ch.overflow       = out_ovf_r;

endmodule

// ===== rtl/sng_chk.sv =====
`timescale 1ns / 1ps

module sng_chk import sng_pkg::*; #(
  parameter int MAX_SURFELS = MAX_SURFELS_DEF
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  in_cmd,
  input logic                  in_last_entry,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [IDX_W-1:0]      out_surfel_index,
  input logic [MASK_OUT_W-1:0] out_neighbour_mask,
  input logic                  out_overflow
);

  // no word pending right after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out valid after reset");

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_surfel_index)
      && $stable(out_neighbour_mask) && $stable(out_overflow))
    else $error("stalled result changed");

  // a final entry starts the walk or the emit, input side goes busy
  a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_cmd == CMD_ADD) && in_last_entry |=> !in_ready)
    else $error("input ready during walk");

  // only earlier surfels can be neighbours
  a_mask_earlier: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (MAX_SURFELS <= MASK_OUT_W)
      |-> ((out_neighbour_mask >> out_surfel_index) == '0))
    else $error("neighbour bit at or above own index");

endmodule

bind surfel_neighbour_graph sng_chk #(
  .MAX_SURFELS (MAX_SURFELS)
) u_sng_chk (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_ch.valid),
  .in_ready           (in_ch.ready),
  .in_cmd             (in_ch.cmd),
  .in_last_entry      (in_ch.last_entry),
  .out_valid          (out_ch.valid),
  .out_ready          (out_ch.ready),
  .out_surfel_index   (out_ch.surfel_index),
  .out_neighbour_mask (out_ch.neighbour_mask),
  .out_overflow       (out_ch.overflow)
);

// ===== dv/sng_checker.sv =====
`timescale 1ns / 1ps

module sng_checker import sng_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  sng_in_if    in_mon,
  sng_out_if   out_mon,
  input  logic cfg_we,
  input  logic cfg_wdata,
  output int   fail_count,
  output int   results_pending
);

  localparam int SLOTS      = MAX_SURFELS_DEF;
  localparam int PER_SURFEL = MAX_FRAMES_DEF;
  localparam int COORD_MASK = (1 << COORD_BITS_DEF) - 1;

  typedef struct packed {
    logic [IDX_W-1:0]      surfel_index;
    logic [MASK_OUT_W-1:0] neighbour_mask;
    logic                  overflow;
  } completion_t;

  // shadow of the entry store, the fill counters and the adjacency select
  logic [FRAME_W-1:0] frame_mem [SLOTS*PER_SURFEL];
  logic [PIX_W-1:0]   col_mem   [SLOTS*PER_SURFEL];
  logic [PIX_W-1:0]   row_mem   [SLOTS*PER_SURFEL];
  int                 entry_count [SLOTS];
  int                 surfels_held;
  int                 fill;
  bit                 dropped;
  bit                 eight_conn;
  completion_t        completions_due [$];
  int                 mismatches = 0;

  function automatic bit pixels_touch(int p, int q);
    int dx, dy;
    if (frame_mem[p] != frame_mem[q]) return 1'b0;
    dx = int'(col_mem[p]) - int'(col_mem[q]);
    dy = int'(row_mem[p]) - int'(row_mem[q]);
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    if (dx == 0 && dy == 0) return 1'b0;
    if (eight_conn) return dx <= 1 && dy <= 1;
    return dx + dy == 1;
  endfunction

  // merge walk of two stored entry lists, in stored order
  function automatic bit surfels_touch(int a, int b);
    int i, j, pa, pb;
    i = 0;
    j = 0;
    while (i < entry_count[a] && j < entry_count[b]) begin
      pa = a * PER_SURFEL + i;
      pb = b * PER_SURFEL + j;
      if (frame_mem[pa] == frame_mem[pb]) begin
        if (pixels_touch(pa, pb)) return 1'b1;
        i++;
        j++;
      end else if (frame_mem[pa] < frame_mem[pb]) begin
        i++;
      end else begin
        j++;
      end
    end
    return 1'b0;
  endfunction

  function automatic void absorb_word(logic cmd, logic [FRAME_W-1:0] frame,
                                      logic [PIX_W-1:0] px, logic [PIX_W-1:0] py,
                                      logic last);
    int slot;
    completion_t done;
    logic [MASK_OUT_W-1:0] mask;
    if (cmd == CMD_CLEAR) begin
      foreach (entry_count[k]) entry_count[k] = 0;
      surfels_held = 0;
      fill = 0;
      dropped = 1'b0;
      return;
    end
    if (surfels_held >= SLOTS) begin
      // store full: entry dropped, a final one still reports
      dropped = 1'b1;
      fill = 0;
      if (last) begin
        done.surfel_index = '0;
        done.neighbour_mask = '0;
        done.overflow = 1'b1;
        completions_due = {completions_due, done};
      end
      return;
    end
    if (fill < PER_SURFEL) begin
      slot = surfels_held * PER_SURFEL + fill;
      frame_mem[slot] = frame;
      col_mem[slot] = PIX_W'(px & COORD_MASK);
      row_mem[slot] = PIX_W'(py & COORD_MASK);
      fill++;
    end else begin
      dropped = 1'b1;
    end
    if (!last) return;
    entry_count[surfels_held] = fill;
    mask = '0;
    for (int k = 0; k < surfels_held; k++) begin
      if (k < MASK_OUT_W && surfels_touch(k, surfels_held)) mask[k] = 1'b1;
    end
    done.surfel_index = IDX_W'(surfels_held);
    done.neighbour_mask = mask;
    done.overflow = dropped;
    completions_due = {completions_due, done};
    surfels_held++;
    fill = 0;
  endfunction

  always @(posedge clk) begin
    completion_t want;
    if (!rst_n) begin
      foreach (entry_count[k]) entry_count[k] = 0;
      surfels_held = 0;
      fill = 0;
      dropped = 1'b0;
      eight_conn = 1'b0;
      completions_due.delete();
    end else begin
      // result side first: a word leaving now belongs to an older entry
      if (out_mon.valid && out_mon.ready) begin
        if (completions_due.size() == 0) begin
          $display("%0t: unexpected result word: expected none, actual index %0d mask %h ovf %0b",
                   $time, out_mon.surfel_index, out_mon.neighbour_mask, out_mon.overflow);
          mismatches++;
        end else begin
          want = completions_due.pop_front();
          if (want.surfel_index !== out_mon.surfel_index) begin
            $display("%0t: surfel_index expected %0d, actual %0d",
                     $time, want.surfel_index, out_mon.surfel_index);
            mismatches++;
          end
          if (want.neighbour_mask !== out_mon.neighbour_mask) begin
            $display("%0t: neighbour_mask expected %h, actual %h",
                     $time, want.neighbour_mask, out_mon.neighbour_mask);
            mismatches++;
          end
          if (want.overflow !== out_mon.overflow) begin
            $display("%0t: overflow expected %0b, actual %0b",
                     $time, want.overflow, out_mon.overflow);
            mismatches++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready)
        absorb_word(in_mon.cmd, in_mon.frame_index, in_mon.pixel_x, in_mon.pixel_y,
                    in_mon.last_entry);
      if (cfg_we) eight_conn = cfg_wdata;
    end
    fail_count <= mismatches;
    results_pending <= completions_due.size();
  end

endmodule

// ===== dv/tb_surfel_neighbour_graph.sv =====
`timescale 1ns / 1ps

module tb_surfel_neighbour_graph;
  import sng_pkg::*;

  localparam int WORDS_TOTAL = 1550;
  // quiet cycles before giving up: a full-store walk holds ready low, and long
  // random stalls can come on either side
  localparam int QUIET_LIMIT = 20000;
  // extra cycles after the last result, for a trailing clear or non-final word
  localparam int SETTLE_CYCLES = 8;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we;
  logic cfg_wdata;

  int send_idle_pct = 0;
  int stall_pct = 0;
  int words_sent = 0;
  int quiet_cycles = 0;
  int fail_count;
  int results_pending;

  sng_in_if  in_ch ();
  sng_out_if out_ch ();

  surfel_neighbour_graph dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  sng_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_mon          (in_ch),
    .out_mon         (out_ch),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .fail_count      (fail_count),
    .results_pending (results_pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver: ready dropped at random per the current phase
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  // watchdog: any accepted word on either channel counts as progress
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, QUIET_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // One word into in_ch. Random idle gaps come first; valid stays high across
  // back-to-back words so it is never lowered and raised in one step.
  task automatic send_word(logic cmd, logic [FRAME_W-1:0] frame,
                           logic [PIX_W-1:0] px, logic [PIX_W-1:0] py, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.cmd         <= cmd;
    in_ch.frame_index <= frame;
    in_ch.pixel_x     <= px;
    in_ch.pixel_y     <= py;
    in_ch.last_entry  <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    words_sent++;
  endtask

  // Hold the sender until every expected result is out, then let any
  // trailing non-final word or clear finish inside the block.
  task automatic settle();
    in_ch.valid <= 1'b0;
    // let the checker count the word just accepted before polling
    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // only called with the block idle
  task automatic set_adjacency(logic eight);
    cfg_we    <= 1'b1;
    cfg_wdata <= eight;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // A batch of surfels around one spot and one frame window, so merge walks
  // hit equal frames and near pixels often. Some surfels are scattered noise
  // (random frames, often out of order), some are overlong, and now and then
  // a clear lands mid-surfel.
  task automatic play_session(int surfels_wanted);
    logic [PIX_W-1:0]   cx, cy;
    logic [FRAME_W-1:0] fr, base_frame;
    int len, pick;
    bit scatter;
    cx = PIX_W'($urandom_range(4095));
    cy = PIX_W'($urandom_range(4095));
    base_frame = FRAME_W'($urandom_range(255));
    for (int s = 0; s < surfels_wanted; s++) begin
      pick = $urandom_range(99);
      if (pick < 5) begin
        len = $urandom_range(9, 11);   // longer than a slot holds
      end else if (pick < 10) begin
        len = MAX_FRAMES_DEF;
      end else begin
        len = $urandom_range(1, 4);
      end
      scatter = ($urandom_range(99) < 15);
      fr = base_frame;
      for (int e = 0; e < len; e++) begin
        if ($urandom_range(99) < 2)
          send_word(CMD_CLEAR, FRAME_W'($urandom_range(255)), PIX_W'($urandom_range(4095)),
                    PIX_W'($urandom_range(4095)), 1'($urandom_range(1)));
        if (scatter) begin
          send_word(CMD_ADD, FRAME_W'($urandom_range(255)), PIX_W'($urandom_range(4095)),
                    PIX_W'($urandom_range(4095)), e == len - 1);
        end else begin
          send_word(CMD_ADD, fr, PIX_W'(cx + $urandom_range(2)), PIX_W'(cy + $urandom_range(2)),
                    e == len - 1);
          if (fr < 8'd254) fr = fr + FRAME_W'($urandom_range(2));
        end
      end
    end
  endtask

  initial begin
    int goal;
    int surfels;
    bit fill_store;
    in_ch.valid       = 1'b0;
    in_ch.cmd         = CMD_ADD;
    in_ch.frame_index = '0;
    in_ch.pixel_x     = '0;
    in_ch.pixel_y     = '0;
    in_ch.last_entry  = 1'b0;
    out_ch.ready      = 1'b0;
    cfg_we            = 1'b0;
    cfg_wdata         = 1'b0;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed, 4-connected
    set_adjacency(1'b0);
    send_word(CMD_ADD, 8'd0, 12'd0, 12'd0, 1'b1);      // first surfel, empty mask
    send_word(CMD_ADD, 8'd0, 12'd1, 12'd0, 1'b1);      // side neighbour of 0
    send_word(CMD_ADD, 8'd0, 12'd1, 12'd1, 1'b1);      // diagonal to 0: not adjacent
    send_word(CMD_ADD, 8'd0, 12'd0, 12'd0, 1'b1);      // same pixel as 0: never adjacent
    send_word(CMD_ADD, 8'd255, 12'd4095, 12'd4095, 1'b0);
    send_word(CMD_ADD, 8'd255, 12'd4095, 12'd4094, 1'b1);  // top corner, equal frames
    send_word(CMD_ADD, 8'd5, 12'd10, 12'd10, 1'b0);
    send_word(CMD_ADD, 8'd3, 12'd20, 12'd20, 1'b1);    // frames out of order
    for (int e = 0; e <= MAX_FRAMES_DEF; e++)          // one word too many: dropped
      send_word(CMD_ADD, FRAME_W'(e), 12'd2, 12'd0, e == MAX_FRAMES_DEF);
    send_word(CMD_CLEAR, 8'd255, 12'd4095, 12'd4095, 1'b1);  // fields ignored
    settle();

    // directed, 8-connected
    set_adjacency(1'b1);
    send_word(CMD_ADD, 8'd7, 12'd100, 12'd100, 1'b1);
    send_word(CMD_ADD, 8'd7, 12'd101, 12'd101, 1'b1);  // diagonal now counts
    send_word(CMD_ADD, 8'd6, 12'd0, 12'd0, 1'b0);
    send_word(CMD_ADD, 8'd7, 12'd102, 12'd102, 1'b1);  // walk skips frame 6

    // random phases: no idling, sender idle, receiver stalling, both;
    // each under both adjacency settings
    fill_store = 1'b1;
    for (int ph = 0; ph < 8; ph++) begin
      settle();
      case (ph / 2)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 84; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 84; end
        default: begin send_idle_pct = 18; stall_pct = 18; end
      endcase
      set_adjacency(ph % 2 == 1);
      goal = words_sent + (WORDS_TOTAL - words_sent) / (8 - ph);
      while (words_sent < goal) begin
        if (fill_store) begin
          surfels = MAX_SURFELS_DEF + 2;   // make sure the store fills at least once
        end else if ($urandom_range(99) < 10) begin
          surfels = $urandom_range(33, 38);
        end else begin
          surfels = $urandom_range(1, 16);
        end
        fill_store = 1'b0;
        play_session(surfels);
        if ($urandom_range(99) < 70)
          send_word(CMD_CLEAR, FRAME_W'($urandom_range(255)), PIX_W'($urandom_range(4095)),
                    PIX_W'($urandom_range(4095)), 1'($urandom_range(1)));
        // sometimes hold off until the block has drained completely
        if ($urandom_range(99) < 10) settle();
      end
    end

    settle();
    if (fail_count == 0 && results_pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== surfel_neighbour_graph.f =====
rtl/sng_pkg.sv
rtl/sng_if.sv
rtl/sng_ram.sv
rtl/sng_adj.sv
rtl/surfel_neighbour_graph.sv
rtl/sng_chk.sv
dv/sng_checker.sv
dv/tb_surfel_neighbour_graph.sv
